@@ rtl/stramp_pkg.sv @@
`timescale 1ns / 1ps

package stramp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DELAY_STEP     = 2'd0;
  localparam logic [1:0] CFG_RAMP_STEPS     = 2'd1;
  localparam logic [1:0] CFG_DELAY_CEILING  = 2'd2;
  localparam logic [1:0] CFG_POSITION_LIMIT = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  DELAY_STEP_RST     = 8'd15;
  localparam logic [9:0]  RAMP_STEPS_RST     = 10'd20;
  localparam logic [15:0] DELAY_CEILING_RST  = 16'd4000;
  localparam logic [14:0] POSITION_LIMIT_RST = 15'd28246;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // One result word
  typedef struct packed {
    logic        status;
    logic        move_done;
    logic [15:0] delay_value;
    logic        direction;
    logic        pulse_level;
  } result_t;

endpackage

@@ rtl/stepper_trapezoid_ramp.sv @@
`timescale 1ns / 1ps

// Trapezoidal ramp generator for one stepper move, counting in half-steps.
// A load word (in_tuser = 0) checks the target against position_limit and
// either rejects it (status 1, nothing changes) or starts a new move with the
// given start delay. Each tick word (in_tuser = 1) during a move is one pulse
// edge: it toggles the pulse line, sets the direction, counts one half-step and
// shortens or lengthens the delay along the ramp; when no move is under way a
// tick changes nothing. Every input word yields exactly one result word. The
// state update and the result are formed in a single combinational pass and
// the result is registered, so a new word is taken every cycle while the result
// side keeps up. Configuration writes take effect on the next cycle.
module stepper_trapezoid_ramp
  import stramp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [14:0] target_position, [30:15] start_delay, [31] zero
  input  logic        in_tuser,   // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] pulse_level, [1] direction, [17:2] delay_value,
                                  // [18] move_done, [19] status, [23:20] zero
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers
  logic [7:0]  delay_step_r;
  logic [9:0]  ramp_steps_r;
  logic [15:0] delay_ceiling_r;
  logic [14:0] position_limit_r;

  // Move state
  logic [14:0]        pos_r, pos_nxt;
  logic signed [16:0] to_go_r, to_go_nxt;
  logic [15:0]        done_r, done_nxt;
  logic [15:0]        delay_r, delay_nxt;
  logic               pulse_r, pulse_nxt;
  logic               dir_r, dir_nxt;

  // Output register
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic        accept;
  logic        req_type;
  logic [14:0] target;
  logic [15:0] start_delay;

  logic [16:0] to_go_neg;
  logic [15:0] mag;
  logic [15:0] mag_nxt;
  logic [16:0] ramp_h;
  logic [17:0] long_thresh;
  logic        long_move;
  logic        active;
  logic [16:0] dec_sum;
  logic [16:0] inc_sum;
  logic [16:0] done_x2;
  logic [17:0] done_plus_ramp;
  logic [15:0] diff;
  logic        reject;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = !out_valid_r || out_tready;
  assign req_type    = in_tuser;
  assign target      = in_tdata[14:0];
  assign start_delay = in_tdata[30:15];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_step_r     <= DELAY_STEP_RST;
      ramp_steps_r     <= RAMP_STEPS_RST;
      delay_ceiling_r  <= DELAY_CEILING_RST;
      position_limit_r <= POSITION_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DELAY_STEP:     delay_step_r     <= cfg_wdata[7:0];
        CFG_RAMP_STEPS:     ramp_steps_r     <= cfg_wdata[9:0];
        CFG_DELAY_CEILING:  delay_ceiling_r  <= cfg_wdata;
        CFG_POSITION_LIMIT: position_limit_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Magnitude of the distance and ramp bounds
  assign to_go_neg      = 17'(-to_go_r);
  assign mag            = to_go_r[16] ? to_go_neg[15:0] : to_go_r[15:0];
  assign ramp_h         = {6'd0, ramp_steps_r, 1'b0};
  assign long_thresh    = {6'd0, ramp_steps_r, 2'b10};
  assign long_move      = {2'b00, mag} > long_thresh;
  assign active         = (mag != 16'd0) && (done_r < mag);
  assign dec_sum        = {1'b0, delay_r} - {9'd0, delay_step_r};
  assign inc_sum        = {1'b0, delay_r} + {9'd0, delay_step_r};
  assign done_x2        = {done_r, 1'b0};
  assign done_plus_ramp = {2'b00, done_r} + {1'b0, ramp_h};
  assign diff           = {1'b0, target} - {1'b0, pos_r};
  assign reject         = target > position_limit_r;

  // Next state for one word
  always_comb begin
    pos_nxt   = pos_r;
    to_go_nxt = to_go_r;
    done_nxt  = done_r;
    delay_nxt = delay_r;
    pulse_nxt = pulse_r;
    dir_nxt   = dir_r;
    if (req_type == REQ_LOAD) begin
      if (!reject) begin
        to_go_nxt = {diff, 1'b0};
        done_nxt  = 16'd0;
        delay_nxt = start_delay;
        pos_nxt   = target;
      end
    end else if (active) begin
      if (long_move) begin
        if ({1'b0, done_r} < ramp_h) begin
          // speed up only while delay - step stays above one
          if (delay_r > {8'd0, delay_step_r} + 16'd1) delay_nxt = dec_sum[15:0];
        end else if (done_plus_ramp > {2'b00, mag}) begin
          if (inc_sum < {1'b0, delay_ceiling_r}) delay_nxt = inc_sum[15:0];
        end
      end else begin
        if (done_x2 < {1'b0, mag}) begin
          // speed up, floor at zero
          if (delay_r > 16'd1) delay_nxt = dec_sum[16] ? 16'd0 : dec_sum[15:0];
        end else if (done_x2 > {1'b0, mag}) begin
          // slow down, clamp at full scale
          if (delay_r < delay_ceiling_r) delay_nxt = inc_sum[16] ? 16'hFFFF : inc_sum[15:0];
        end
      end
      dir_nxt   = !to_go_r[16];
      pulse_nxt = !pulse_r;
      done_nxt  = done_r + 16'd1;
    end
  end

  // Result from the updated state
  assign mag_nxt = to_go_nxt[16] ? 16'(-to_go_nxt) : to_go_nxt[15:0];

  always_comb begin
    res_nxt.pulse_level = pulse_nxt;
    res_nxt.direction   = dir_nxt;
    res_nxt.delay_value = delay_nxt;
    res_nxt.move_done   = (done_nxt == mag_nxt);
    res_nxt.status      = (req_type == REQ_LOAD && reject) ? STATUS_REJECTED : STATUS_OK;
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      to_go_r <= '0;
      done_r  <= '0;
      delay_r <= '0;
      pulse_r <= 1'b0;
      dir_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      to_go_r <= to_go_nxt;
      done_r  <= done_nxt;
      delay_r <= delay_nxt;
      pulse_r <= pulse_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};

endmodule

@@ dv/stepper_trapezoid_ramp_test.sv @@
`timescale 1ns / 1ps

module stepper_trapezoid_ramp_test;
  import stramp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [14:0] target_position, [30:15] start_delay, [31] zero
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [0] pulse_level, [1] direction, [17:2] delay_value,
                           // [18] move_done, [19] status, [23:20] zero
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  stepper_trapezoid_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Free-running clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirrored configuration
  logic [7:0]  ramp_delay_step;
  logic [9:0]  ramp_len;
  logic [15:0] ramp_ceiling;
  logic [14:0] ramp_pos_limit;

  // Mirrored move state
  logic [15:0] move_pos;
  int          move_to_go;
  logic [16:0] move_done_cnt;
  logic [15:0] move_delay;
  logic        move_pulse;
  logic        move_dir;

  result_t expected_words[$];
  int      words_sent;
  int      mismatches;
  int      send_burst;
  int      recv_burst;

  // Pick an idle gap; now and then run a stretch with no gaps at all
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  // Apply one word to the mirrored state and form the result it should give
  function automatic result_t advance_ramp(logic req, logic [14:0] tgt, logic [15:0] start);
    result_t r;
    logic    st;
    int      mag;
    int      ramp_h;
    int      dn;
    int      dec;
    int      inc;
    st = STATUS_OK;
    mag = (move_to_go < 0) ? -move_to_go : move_to_go;
    dn = int'(move_done_cnt);
    if (req == REQ_LOAD) begin
      if (tgt > ramp_pos_limit) begin
        st = STATUS_REJECTED;
      end else begin
        move_to_go = 2 * (int'(tgt) - int'(move_pos));
        move_done_cnt = '0;
        move_delay = start;
        move_pos = {1'b0, tgt};
      end
    end else if (mag != 0 && dn < mag) begin
      ramp_h = 2 * int'(ramp_len);
      dec = int'(move_delay) - int'(ramp_delay_step);
      inc = int'(move_delay) + int'(ramp_delay_step);
      if (mag > 2 * (2 * int'(ramp_len) + 1)) begin
        // long move: full ramps at both ends
        if (dn < ramp_h) begin
          if (dec > 1) move_delay = 16'(dec);
        end else if (dn > mag - ramp_h) begin
          if (inc < int'(ramp_ceiling)) move_delay = 16'(inc);
        end
      end else begin
        // short move: turn around at the midpoint
        if (2 * dn < mag) begin
          if (move_delay > 16'd1) move_delay = (dec < 0) ? 16'd0 : 16'(dec);
        end else if (2 * dn > mag) begin
          if (move_delay < ramp_ceiling) move_delay = (inc > 65535) ? 16'hFFFF : 16'(inc);
        end
      end
      move_dir = (move_to_go > 0);
      move_pulse = ~move_pulse;
      move_done_cnt = move_done_cnt + 17'd1;
    end
    mag = (move_to_go < 0) ? -move_to_go : move_to_go;
    r.pulse_level = move_pulse;
    r.direction   = move_dir;
    r.delay_value = move_delay;
    r.move_done   = (int'(move_done_cnt) == mag);
    r.status      = st;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // Send one word with a random lead-in gap and record its expected result
  task automatic send_word(logic req, logic [14:0] tgt, logic [15:0] start);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= req;
    in_tdata  <= {1'b0, start, tgt};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(advance_ramp(req, tgt, start));
    words_sent++;
  endtask

  // Ticks carry junk in the unused fields
  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_word(REQ_TICK, 15'($urandom), 16'($urandom));
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic set_config(logic [7:0] ds, logic [9:0] rs, logic [15:0] dc, logic [14:0] pl);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{CFG_DELAY_STEP, CFG_RAMP_STEPS, CFG_DELAY_CEILING, CFG_POSITION_LIMIT};
    val = '{{8'd0, ds}, {6'd0, rs}, dc, {1'b0, pl}};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ramp_delay_step = ds;
    ramp_len        = rs;
    ramp_ceiling    = dc;
    ramp_pos_limit  = pl;
    @(posedge clk);
  endtask

  // Reset settings: empty move, limit boundary, both directions
  task automatic test_after_reset();
    send_word(REQ_TICK, 15'd0, 16'd0);
    send_word(REQ_LOAD, 15'd32767, 16'hFFFF);
    send_word(REQ_LOAD, 15'd28247, 16'd100);
    send_word(REQ_LOAD, 15'd28246, 16'd0);
    send_word(REQ_TICK, 15'd0, 16'd0);
    send_word(REQ_LOAD, 15'd0, 16'hFFFF);
    send_word(REQ_TICK, 15'h7FFF, 16'hFFFF);
  endtask

  // Long move: reduction only while the difference stays above one, ceiling bound
  task automatic test_long_ramp_bounds();
    set_config(8'd15, 10'd1, 16'd17, 15'd32767);
    send_word(REQ_LOAD, 15'd4, 16'd17);
    send_ticks(9);
  endtask

  // Short move: saturation at zero, midpoint hold, rejection at limit zero
  task automatic test_short_move();
    set_config(8'd255, 10'd1023, 16'd65535, 15'd0);
    send_word(REQ_LOAD, 15'd1, 16'd300);
    send_word(REQ_LOAD, 15'd0, 16'd300);
    send_ticks(9);
  endtask

  // Short move long enough to push the delay past 16 bits
  task automatic test_delay_saturation();
    set_config(8'd255, 10'd1023, 16'd65535, 15'd32767);
    send_word(REQ_LOAD, 15'd260, 16'd1);
    send_ticks(521);
    send_word(REQ_LOAD, 15'd0, 16'd2);
    send_ticks(5);
  endtask

  // Mostly complete moves with random content, plus noise and cut-short moves
  task automatic test_random_moves(int n_words, int max_full);
    int          first;
    int          kind;
    int          t;
    int          left;
    logic [14:0] tgt;
    logic [15:0] sd;
    first = words_sent;
    while (words_sent - first < n_words) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       sd = 16'($urandom_range(0, 3));
        1:       sd = 16'($urandom_range(0, 300));
        2:       sd = 16'(65535 - $urandom_range(0, 300));
        default: sd = 16'($urandom);
      endcase
      if (kind == 0) begin
        tgt = 15'($urandom);
      end else if (kind == 1 && ramp_pos_limit < 15'h7FFF) begin
        tgt = 15'($urandom_range(int'(ramp_pos_limit) + 1, 32767));
      end else begin
        t = int'(move_pos);
        if ($urandom_range(0, 1)) t = t + $urandom_range(0, max_full);
        else t = t - $urandom_range(0, max_full);
        if (t < 0) t = 0;
        if (t > int'(ramp_pos_limit)) t = int'(ramp_pos_limit);
        tgt = 15'(t);
      end
      send_word(REQ_LOAD, tgt, sd);
      left = ((move_to_go < 0) ? -move_to_go : move_to_go) - int'(move_done_cnt);
      if (left > 600) send_ticks($urandom_range(0, 40));
      else if (kind == 2) send_ticks($urandom_range(0, left));
      else send_ticks(left + $urandom_range(0, 2));
    end
  endtask

  // Result side: random stall per word, compare against the oldest expectation
  initial begin
    result_t got;
    result_t want;
    int      gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = result_t'(out_tdata[19:0]);
      if (expected_words.size() == 0) begin
        report_mismatch("result with no word pending", 32'(out_tdata), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (got.pulse_level !== want.pulse_level)
          report_mismatch("pulse_level", 32'(got.pulse_level), 32'(want.pulse_level));
        if (got.direction !== want.direction)
          report_mismatch("direction", 32'(got.direction), 32'(want.direction));
        if (got.delay_value !== want.delay_value)
          report_mismatch("delay_value", 32'(got.delay_value), 32'(want.delay_value));
        if (got.move_done !== want.move_done)
          report_mismatch("move_done", 32'(got.move_done), 32'(want.move_done));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_LOAD;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_DELAY_STEP;
    cfg_wdata  = '0;
    words_sent = 0;
    mismatches = 0;
    send_burst = 0;
    recv_burst = 0;
    ramp_delay_step = DELAY_STEP_RST;
    ramp_len        = RAMP_STEPS_RST;
    ramp_ceiling    = DELAY_CEILING_RST;
    ramp_pos_limit  = POSITION_LIMIT_RST;
    move_pos      = '0;
    move_to_go    = 0;
    move_done_cnt = '0;
    move_delay    = '0;
    move_pulse    = 1'b0;
    move_dir      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_after_reset();
    test_long_ramp_bounds();
    test_short_move();
    test_delay_saturation();

    set_config(8'($urandom), 10'($urandom_range(0, 12)), 16'($urandom), 15'd32767);
    test_random_moves(400, 40);
    set_config(8'd0, 10'd0, 16'd0, 15'd0);
    test_random_moves(120, 10);
    set_config(8'd255, 10'd1023, 16'd65535, 15'd32767);
    test_random_moves(300, 60);
    set_config(8'($urandom), 10'($urandom_range(0, 6)), 16'($urandom_range(0, 400)),
               15'($urandom_range(50, 32767)));
    test_random_moves(500, 30);

    settle();
    repeat (10) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("results left over", 32'(expected_words.size()), 32'd0);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ stepper_trapezoid_ramp.f @@
rtl/stramp_pkg.sv
rtl/stepper_trapezoid_ramp.sv
dv/stepper_trapezoid_ramp_test.sv
